FILE: rtl/pec_pkg.sv
// Shared constants, codes and types for the polynomial easing curve.
package pec_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VW        = FRAC_BITS + 1;   // value width, holds 0 .. 1.0
	localparam int PRW       = 2 * VW;          // full product width
	localparam int NCELLS    = 5;               // highest supported power
	localparam int PW        = 3;               // curve_power width
	localparam int SHW       = VW + NCELLS;     // width after scaling by 2^n
	localparam int CFG_IW    = 1;               // register index width
	localparam int CFG_DW    = 3;               // widest register

	localparam logic [VW-1:0]  ONE    = VW'(1) << FRAC_BITS;
	localparam logic [VW-1:0]  HALF   = VW'(1) << (FRAC_BITS - 1);
	localparam logic [SHW-1:0] ONE_SH = SHW'(1) << FRAC_BITS;

	localparam logic [PW-1:0] PWR_MIN   = PW'(1);
	localparam logic [PW-1:0] PWR_MAX   = PW'(NCELLS);
	localparam logic [PW-1:0] PWR_RESET = PW'(2);

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_POWER   = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_VARIANT = 1'b1;

	// curve variants
	localparam logic [1:0] VAR_IN    = 2'd0;
	localparam logic [1:0] VAR_OUT   = 2'd1;
	localparam logic [1:0] VAR_INOUT = 2'd2;
	localparam logic [1:0] VAR_SPIKE = 2'd3;

	typedef struct packed {
		logic [VW-1:0] p;         // running power
		logic [VW-1:0] x;         // base, t or 1-t
		logic [PW-1:0] pwr;       // clamped exponent
		logic [1:0]    variant;
		logic          low_half;  // t <= 0.5
	} cell_t;

endpackage

FILE: rtl/pec_time_if.sv
// Stream channel carrying time samples.
interface pec_time_if;
	logic                 valid;
	logic                 ready;
	logic [pec_pkg::VW-1:0] time_sample;

	modport source (output valid, output time_sample, input ready);
	modport sink (input valid, input time_sample, output ready);
endinterface

FILE: rtl/pec_ease_if.sv
// Stream channel carrying eased curve values.
interface pec_ease_if;
	logic                 valid;
	logic                 ready;
	logic [pec_pkg::VW-1:0] eased_value;

	modport source (output valid, output eased_value, input ready);
	modport sink (input valid, input eased_value, output ready);
endinterface

FILE: rtl/pec_cell.sv
// One multiply cell of the power chain: p <= p*x >> FRAC_BITS when active.
module pec_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [pec_pkg::PW-1:0] idx,
	input  logic                   d_vld,
	output logic                   d_rdy,
	input  pec_pkg::cell_t         d,
	output logic                   q_vld,
	input  logic                   q_rdy,
	output pec_pkg::cell_t         q
);
	import pec_pkg::*;

	logic           vld_q;
	cell_t          c_q;
	cell_t          c_nxt;
	logic           adv;
	logic [PRW-1:0] prod;

	assign adv  = !vld_q || q_rdy;
	assign d_rdy = adv;
	assign prod = PRW'(d.p) * PRW'(d.x);

	// cells at or beyond the exponent pass p through
	always_comb begin
		c_nxt = d;
		if (idx < d.pwr) begin
			c_nxt.p = prod[FRAC_BITS +: VW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && d_vld) begin
			c_q <= c_nxt;
		end
	end

	assign q_vld = vld_q;
	assign q     = c_q;
endmodule

FILE: rtl/power_easing_curve.sv
// Top level of the polynomial easing curve evaluator.
//
// Channels: samples (sink) takes one time_sample per beat, unsigned with
// FRAC_BITS fraction bits; values above 1.0 clamp to 1.0. eased (source)
// gives one eased_value per accepted sample, in order, within [0, 1.0].
// Config: cfg_we/cfg_idx/cfg_wdata write curve_power (index 0) and
// curve_variant (index 1); write only while no sample is in flight.
// Path: the entry stage loads an accepted sample at the accepting edge, then
// the five multiply cells and the output stage register it in turn.
// Throughput: one sample per cycle unless eased.ready stalls, set by one
// 17x17 multiplier per cell; each stage has its own valid bit, so bubbles close up.
// Reset: arst_n clears all valid bits and loads power 2, variant in.
// Stall: while eased.ready is low the result holds; upstream stages keep
// accepting until the chain is full, then samples.ready drops.
module power_easing_curve (
	input  logic                       clk,
	input  logic                       arst_n,
	pec_time_if.sink                   samples,
	pec_ease_if.source                 eased,
	input  logic                       cfg_we,
	input  logic [pec_pkg::CFG_IW-1:0] cfg_idx,
	input  logic [pec_pkg::CFG_DW-1:0] cfg_wdata
);
	import pec_pkg::*;

	// configuration registers
	logic [PW-1:0] power_q;
	logic [1:0]    variant_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q   <= PWR_RESET;
			variant_q <= VAR_IN;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_POWER:   power_q   <= cfg_wdata[PW-1:0];
				CFG_VARIANT: variant_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// entry stage: clamp t, pick base, clamp exponent
	logic          vld_s0;
	cell_t         c_s0;
	logic          rdy_s0;
	logic          adv_s0;
	logic [VW-1:0] t_cl;
	logic [VW-1:0] u_cl;
	logic          low_half;
	logic [PW-1:0] pwr_cl;
	cell_t         c_in;

	assign adv_s0        = !vld_s0 || rdy_s0;
	assign samples.ready = adv_s0;

	always_comb begin
		t_cl     = (samples.time_sample > ONE) ? ONE : samples.time_sample;
		u_cl     = ONE - t_cl;
		low_half = (t_cl <= HALF);
		if (power_q < PWR_MIN) begin
			pwr_cl = PWR_MIN;
		end else if (power_q > PWR_MAX) begin
			pwr_cl = PWR_MAX;
		end else begin
			pwr_cl = power_q;
		end
		c_in.p        = ONE;
		c_in.pwr      = pwr_cl;
		c_in.variant  = variant_q;
		c_in.low_half = low_half;
		unique case (variant_q)
			VAR_IN:  c_in.x = t_cl;
			VAR_OUT: c_in.x = u_cl;
			default: c_in.x = low_half ? t_cl : u_cl;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv_s0) begin
			vld_s0 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s0 && samples.valid) begin
			c_s0 <= c_in;
		end
	end

	// multiply chain: cell k applies the (k+1)-th factor
	logic  ch_vld [NCELLS+1];
	logic  ch_rdy [NCELLS+1];
	cell_t ch_c   [NCELLS+1];

	assign ch_vld[0] = vld_s0;
	assign ch_c[0]   = c_s0;
	assign rdy_s0    = ch_rdy[0];

	for (genvar g = 0; g < NCELLS; g++) begin : g_cell
		pec_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (PW'(g)),
			.d_vld  (ch_vld[g]),
			.d_rdy  (ch_rdy[g]),
			.d      (ch_c[g]),
			.q_vld  (ch_vld[g+1]),
			.q_rdy  (ch_rdy[g+1]),
			.q      (ch_c[g+1])
		);
	end

	// output stage: scale by 2^(n-1) or 2^n, complement, saturate
	logic           out_vld_q;
	logic [VW-1:0]  out_val_q;
	logic           adv_out;
	cell_t          c_end;
	logic [PW-1:0]  sh_amt;
	logic [SHW-1:0] scaled;
	logic [VW-1:0]  r;

	assign c_end          = ch_c[NCELLS];
	assign adv_out        = !out_vld_q || eased.ready;
	assign ch_rdy[NCELLS] = adv_out;

	always_comb begin
		sh_amt = (c_end.variant == VAR_INOUT) ? c_end.pwr - PW'(1) : c_end.pwr;
		scaled = SHW'(c_end.p) << sh_amt;
		unique case (c_end.variant)
			VAR_IN:  r = c_end.p;
			VAR_OUT: r = ONE - c_end.p;
			VAR_INOUT: begin
				if (c_end.low_half) begin
					r = (scaled > ONE_SH) ? ONE : scaled[VW-1:0];
				end else begin
					r = (scaled > ONE_SH) ? '0 : ONE - scaled[VW-1:0];
				end
			end
			default: r = (scaled > ONE_SH) ? ONE : scaled[VW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_out) begin
			out_vld_q <= ch_vld[NCELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && ch_vld[NCELLS]) begin
			out_val_q <= r;
		end
	end

	assign eased.valid       = out_vld_q;
	assign eased.eased_value = out_val_q;

	// result never exceeds 1.0
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		eased.valid |-> eased.eased_value <= ONE)
		else $error("eased value above one");

	// entry stage holds a clamped base and exponent
	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s0 |-> (c_s0.x <= ONE && c_s0.pwr >= PWR_MIN && c_s0.pwr <= PWR_MAX))
		else $error("entry stage out of range");

	// chain end: running power stays within 1.0
	a_chain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ch_vld[NCELLS] |-> c_end.p <= ONE)
		else $error("power above one at chain end");

	// a beat taken by an empty entry stage shows up there next cycle
	a_entry_load: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> vld_s0)
		else $error("accepted beat lost at entry");
endmodule
